// ===== hdl/abclru_pkg.sv =====
// Package for the associative block cache with LRU replacement.
// Holds the sizes, the line-scan state type and the structs shared by the modules.
// No dependencies.
`default_nettype none

package abclru_pkg;

	localparam int LINES   = 16;
	localparam int IDX_W   = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int STAMP_W = 32;
	localparam int TAG_W   = 64;
	localparam int DATA_W  = 64;
	localparam int HITS_W  = 32;
	localparam int CFG_W   = 5;
	localparam int OUT_IDX_W = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} scan_state_t;

	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   node_tag;
		logic [TAG_W-1:0]   block_tag;
		logic [DATA_W-1:0]  data;
		logic [STAMP_W-1:0] stamp;
	} line_view_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [IDX_W-1:0]  where;
		logic [DATA_W-1:0] rdata;
	} scan_res_t;

endpackage

`default_nettype wire

// ===== hdl/abclru_scan.sv =====
// Line scanner: a sequencer that steps one line per cycle through a shared tag
// and stamp compare unit, finding the hit, the first empty line and the LRU line.
// Depends on abclru_pkg.
`default_nettype none

module abclru_scan (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire                              commit,
	input  wire [abclru_pkg::IDX_W-1:0]      last_idx,
	input  wire [abclru_pkg::TAG_W-1:0]      node_id,
	input  wire [abclru_pkg::TAG_W-1:0]      block_id,
	input  abclru_pkg::line_view_t           line,
	output logic [abclru_pkg::IDX_W-1:0]     idx,
	output logic                             ready,
	output abclru_pkg::scan_res_t            res
);

	abclru_pkg::scan_state_t state_q, state_d;

	logic [abclru_pkg::IDX_W-1:0]   idx_q;
	logic                           found_q;
	logic [abclru_pkg::IDX_W-1:0]   hit_idx_q;
	logic [abclru_pkg::DATA_W-1:0]  rdata_q;
	logic                           empty_found_q;
	logic [abclru_pkg::IDX_W-1:0]   empty_idx_q;
	logic [abclru_pkg::STAMP_W-1:0] best_q;
	logic [abclru_pkg::IDX_W-1:0]   best_idx_q;

	logic match;
	logic at_last;
	logic older;

	assign match   = line.valid && (line.node_tag == node_id) && (line.block_tag == block_id);
	assign at_last = (idx_q == last_idx);
	assign older   = (idx_q == '0) || (line.stamp < best_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			abclru_pkg::ST_IDLE: begin
				if (start)
					state_d = abclru_pkg::ST_SCAN;
			end
			abclru_pkg::ST_SCAN: begin
				if (match || at_last)
					state_d = abclru_pkg::ST_WRITE;
			end
			abclru_pkg::ST_WRITE: begin
				if (commit)
					state_d = abclru_pkg::ST_IDLE;
			end
			default: state_d = abclru_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		idx       = idx_q;
		ready     = (state_q == abclru_pkg::ST_IDLE);
		res.done  = (state_q == abclru_pkg::ST_WRITE);
		res.found = found_q;
		res.rdata = rdata_q;
		if (found_q)
			res.where = hit_idx_q;
		else if (empty_found_q)
			res.where = empty_idx_q;
		else
			res.where = best_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= abclru_pkg::ST_IDLE;
			idx_q         <= '0;
			found_q       <= 1'b0;
			empty_found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == abclru_pkg::ST_IDLE && start) begin
				idx_q         <= '0;
				found_q       <= 1'b0;
				empty_found_q <= 1'b0;
			end else if (state_q == abclru_pkg::ST_SCAN) begin
				if (match) begin
					found_q <= 1'b1;
				end else begin
					if (!empty_found_q && !line.valid)
						empty_found_q <= 1'b1;
					if (!at_last)
						idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == abclru_pkg::ST_SCAN) begin
			if (match) begin
				hit_idx_q <= idx_q;
				rdata_q   <= line.data;
			end
			if (!empty_found_q && !line.valid)
				empty_idx_q <= idx_q;
			if (older) begin
				best_q     <= line.stamp;
				best_idx_q <= idx_q;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/assoc_block_cache_lru.sv =====
// Flow: an item is accepted in idle, then one line is examined per cycle until a hit
// or the last line in use, then the write state registers the result; the lines in use
// are lines_in_use clamped to 1 through 16. The next word is accepted the cycle after
// the write, so an item is not taken while the last one is in flight; a result still
// waiting at the output holds the write cycle.
// Reset clears every line (empty), the query and hit counters, and sets lines_in_use to 16.
// Depends on abclru_pkg and abclru_scan.
`default_nettype none

module assoc_block_cache_lru (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// node_id [63:0], block_id [127:64], data_word [191:128]
	input  wire  [191:0] s_tdata,
	// mode [0]
	input  wire  [0:0]   s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// read_data [63:0], line_index [67:64], hit_total [99:68], zero fill [103:100]
	output logic [103:0] m_tdata,
	// hit [0]
	output logic [0:0]   m_tuser,
	input  wire          cfg_we,
	input  wire  [abclru_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int IW = abclru_pkg::IDX_W;

	logic                           valid_q [abclru_pkg::LINES];
	logic [abclru_pkg::TAG_W-1:0]   node_tags_q [abclru_pkg::LINES];
	logic [abclru_pkg::TAG_W-1:0]   block_tags_q [abclru_pkg::LINES];
	logic [abclru_pkg::DATA_W-1:0]  line_data_q [abclru_pkg::LINES];
	logic [abclru_pkg::STAMP_W-1:0] stamps_q [abclru_pkg::LINES];

	logic [abclru_pkg::CFG_W-1:0]   lines_in_use_q;
	logic [abclru_pkg::STAMP_W-1:0] query_q;
	logic [abclru_pkg::HITS_W-1:0]  hits_q;

	logic                           put_q;
	logic [abclru_pkg::TAG_W-1:0]   node_q;
	logic [abclru_pkg::TAG_W-1:0]   block_q;
	logic [abclru_pkg::DATA_W-1:0]  word_q;

	logic                             hit_q;
	logic [abclru_pkg::DATA_W-1:0]    read_data_q;
	logic [abclru_pkg::OUT_IDX_W-1:0] line_index_q;
	logic [abclru_pkg::HITS_W-1:0]    hit_total_q;
	logic                             out_valid_q;

	logic                   scan_ready;
	logic [IW-1:0]          scan_idx;
	logic [IW-1:0]          last_idx;
	abclru_pkg::line_view_t line;
	abclru_pkg::scan_res_t  res;
	logic                   accept;
	logic                   commit;
	logic [abclru_pkg::HITS_W-1:0] hits_next;

	always_comb begin
		if (lines_in_use_q == '0)
			last_idx = '0;
		else if (32'(lines_in_use_q) > abclru_pkg::LINES)
			last_idx = IW'(abclru_pkg::LINES - 1);
		else
			last_idx = IW'(lines_in_use_q - 1'b1);
	end

	assign line.valid     = valid_q[scan_idx];
	assign line.node_tag  = node_tags_q[scan_idx];
	assign line.block_tag = block_tags_q[scan_idx];
	assign line.data      = line_data_q[scan_idx];
	assign line.stamp     = stamps_q[scan_idx];

	assign s_tready  = scan_ready;
	assign accept    = s_tvalid && scan_ready;
	assign commit    = res.done && (!out_valid_q || m_tready);
	assign hits_next = hits_q + {{(abclru_pkg::HITS_W-1){1'b0}}, res.found};

	abclru_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.commit   (commit),
		.last_idx (last_idx),
		.node_id  (node_q),
		.block_id (block_q),
		.line     (line),
		.idx      (scan_idx),
		.ready    (scan_ready),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_in_use_q <= abclru_pkg::CFG_W'(16);
			query_q        <= '0;
			hits_q         <= '0;
			out_valid_q    <= 1'b0;
			for (int i = 0; i < abclru_pkg::LINES; i++)
				valid_q[i] <= 1'b0;
		end else begin
			if (cfg_we)
				lines_in_use_q <= cfg_wdata;
			if (accept)
				query_q <= query_q + 1'b1;
			if (commit)
				out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready)
				out_valid_q <= 1'b0;
			if (commit) begin
				hits_q      <= hits_next;
				if (!res.found && put_q)
					valid_q[res.where] <= (node_q != '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			put_q   <= s_tuser[0];
			node_q  <= s_tdata[63:0];
			block_q <= s_tdata[127:64];
			word_q  <= s_tdata[191:128];
		end
		if (commit) begin
			if (res.found) begin
				stamps_q[res.where] <= query_q;
				if (put_q)
					line_data_q[res.where] <= word_q;
			end else if (put_q) begin
				node_tags_q[res.where]  <= node_q;
				block_tags_q[res.where] <= block_q;
				line_data_q[res.where]  <= word_q;
				stamps_q[res.where]     <= query_q;
			end
			hit_q        <= res.found;
			read_data_q  <= (res.found && !put_q) ? res.rdata : '0;
			line_index_q <= (res.found || put_q) ?
				abclru_pkg::OUT_IDX_W'(res.where) : '0;
			hit_total_q  <= hits_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = hit_q;
	assign m_tdata  = {4'b0000, hit_total_q, line_index_q, read_data_q};

endmodule

`default_nettype wire

// ===== bench/assoc_block_cache_lru_tb.sv =====
// Self-checking testbench for assoc_block_cache_lru, the LRU block cache on stream ports.
// Drives gets and puts over a range of line counts and checks every result word.
// Depends on abclru_pkg and on the assoc_block_cache_lru RTL.
`default_nettype none

module assoc_block_cache_lru_tb;

	localparam bit MODE_GET = 1'b0;
	localparam bit MODE_PUT = 1'b1;
	localparam int POOL_KEYS = 32;

	typedef struct packed {
		logic                          mode;
		logic [abclru_pkg::TAG_W-1:0]  node_id;
		logic [abclru_pkg::TAG_W-1:0]  block_id;
		logic [abclru_pkg::DATA_W-1:0] data_word;
	} access_t;

	typedef struct packed {
		logic                             hit;
		logic [abclru_pkg::DATA_W-1:0]    read_data;
		logic [abclru_pkg::OUT_IDX_W-1:0] line_index;
		logic [abclru_pkg::HITS_W-1:0]    hit_total;
	} outcome_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	wire               s_tready;
	logic [191:0]      s_tdata = '0;
	logic [0:0]        s_tuser = '0;
	wire               m_tvalid;
	logic              m_tready = 1'b0;
	wire  [103:0]      m_tdata;
	wire  [0:0]        m_tuser;
	logic              cfg_we = 1'b0;
	logic [abclru_pkg::CFG_W-1:0] cfg_wdata = '0;

	assoc_block_cache_lru i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	access_t  access_queue[$];
	outcome_t pending_results[$];
	access_t  offered;

	logic [abclru_pkg::TAG_W-1:0]   tag_node   [abclru_pkg::LINES];
	logic [abclru_pkg::TAG_W-1:0]   tag_block  [abclru_pkg::LINES];
	logic [abclru_pkg::DATA_W-1:0]  word_store [abclru_pkg::LINES];
	logic [abclru_pkg::STAMP_W-1:0] stamp_store[abclru_pkg::LINES];
	logic [abclru_pkg::STAMP_W-1:0] query_count;
	logic [abclru_pkg::HITS_W-1:0]  hit_count;
	logic [abclru_pkg::CFG_W-1:0]   lines_setting;

	logic [abclru_pkg::TAG_W-1:0] pool_node [POOL_KEYS];
	logic [abclru_pkg::TAG_W-1:0] pool_block[POOL_KEYS];

	bit calm = 1'b0;
	bit stall_req = 1'b0;
	int fails = 0;
	int words_checked = 0;
	int hits_seen = 0;
	int settings_used = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic cache_access(input access_t a, output outcome_t r);
		int unsigned n;
		int unsigned i;
		int unsigned where;
		bit found;
		bit empty;
		logic [abclru_pkg::STAMP_W-1:0] oldest;
		n = lines_setting;
		if (n < 1) n = 1;
		if (n > abclru_pkg::LINES) n = abclru_pkg::LINES;
		where = 0;
		found = 1'b0;
		empty = 1'b0;
		query_count = query_count + 1'b1;
		for (i = 0; i < n && !found; i++) begin
			if (tag_node[i] != '0 && tag_node[i] == a.node_id && tag_block[i] == a.block_id) begin
				found = 1'b1;
				where = i;
			end
		end
		r = '0;
		r.hit = found;
		if (found) begin
			hit_count = hit_count + 1'b1;
			stamp_store[where] = query_count;
			if (a.mode == MODE_PUT) word_store[where] = a.data_word;
			else r.read_data = word_store[where];
			r.line_index = where[abclru_pkg::OUT_IDX_W-1:0];
		end else if (a.mode == MODE_PUT) begin
			for (i = 0; i < n && !empty; i++) begin
				if (tag_node[i] == '0) begin
					empty = 1'b1;
					where = i;
				end
			end
			if (!empty) begin
				oldest = stamp_store[0];
				where = 0;
				for (i = 1; i < n; i++) begin
					if (stamp_store[i] < oldest) begin
						oldest = stamp_store[i];
						where = i;
					end
				end
			end
			tag_node[where] = a.node_id;
			tag_block[where] = a.block_id;
			word_store[where] = a.data_word;
			stamp_store[where] = query_count;
			r.line_index = where[abclru_pkg::OUT_IDX_W-1:0];
		end
		r.hit_total = hit_count;
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t predicted;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				cache_access(offered, predicted);
				pending_results.push_back(predicted);
			end
			if (!s_tvalid || s_tready) begin
				if (access_queue.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
					offered = access_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {offered.data_word, offered.block_id, offered.node_id};
					s_tuser <= offered.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endfunction

	bit stall_seen = 1'b0;
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.hit = m_tuser[0];
				got.read_data = m_tdata[63:0];
				got.line_index = m_tdata[67:64];
				got.hit_total = m_tdata[99:68];
				if (pending_results.size() == 0) begin
					$error("result word with no access outstanding");
					fails++;
				end else begin
					want = pending_results.pop_front();
					check_field("hit", want.hit, got.hit);
					check_field("read_data", want.read_data, got.read_data);
					check_field("line_index", want.line_index, got.line_index);
					check_field("hit_total", want.hit_total, got.hit_total);
					words_checked++;
					if (got.hit) hits_seen++;
				end
			end
			if (stall_req != stall_seen) begin
				stall_seen = stall_req;
				hold_left = 300;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 38);
			end
		end
	end

	task automatic send(input bit mode, input logic [63:0] node, input logic [63:0] blk,
			input logic [63:0] word);
		access_t a;
		a.mode = mode;
		a.node_id = node;
		a.block_id = blk;
		a.data_word = word;
		access_queue.push_back(a);
	endtask

	task automatic settle();
		@(negedge clk);
		while (access_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_lines(input logic [abclru_pkg::CFG_W-1:0] value);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		lines_setting = value;
		settings_used++;
	endtask

	task automatic random_phase(input int count, input logic [abclru_pkg::CFG_W-1:0] lines,
			input bit no_idle, input bit squeeze);
		int pool_size;
		int put_pct;
		int r;
		int k;
		write_lines(lines);
		pool_size = $urandom_range(28, 2);
		put_pct = $urandom_range(70, 30);
		calm = no_idle;
		for (int j = 0; j < count; j++) begin
			r = $urandom_range(99);
			k = $urandom_range(pool_size - 1);
			if (r < 6)
				send($urandom_range(99) < put_pct, '0, {$urandom, $urandom},
					{$urandom, $urandom});
			else if (r < 14)
				send($urandom_range(99) < put_pct, {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom});
			else
				send($urandom_range(99) < put_pct, pool_node[k], pool_block[k],
					{$urandom, $urandom});
		end
		if (squeeze) stall_req = ~stall_req;
		settle();
		calm = 1'b0;
	endtask

	initial begin
		logic [63:0] key_node[17];
		logic [63:0] key_block[17];
		for (int i = 0; i < abclru_pkg::LINES; i++) begin
			tag_node[i] = '0;
			tag_block[i] = '0;
			word_store[i] = '0;
			stamp_store[i] = '0;
		end
		query_count = '0;
		hit_count = '0;
		lines_setting = 5'd16;
		for (int i = 0; i < POOL_KEYS; i++) begin
			pool_node[i] = {$urandom, $urandom} | 64'h1;
			pool_block[i] = {$urandom, $urandom};
		end
		pool_node[0] = '1;
		pool_block[0] = '1;
		pool_block[1] = '0;
		for (int i = 1; i <= 16; i++) begin
			key_node[i] = {$urandom, $urandom} | 64'h1;
			key_block[i] = {$urandom, $urandom};
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty cache, zero node ids, all-ones keys and data, then a full cache and eviction.
		send(MODE_GET, '0, '0, '0);
		send(MODE_GET, '1, '1, '1);
		send(MODE_PUT, '0, 64'd5, 64'hA5A5_5A5A_0F0F_F0F0);
		send(MODE_PUT, '1, '1, '1);
		send(MODE_GET, '1, '1, '0);
		send(MODE_PUT, '1, '1, '0);
		send(MODE_GET, '1, '1, '1);
		send(MODE_GET, '0, 64'd5, '0);
		for (int i = 1; i <= 15; i++)
			send(MODE_PUT, key_node[i], key_block[i], {$urandom, $urandom});
		send(MODE_PUT, key_node[16], key_block[16], {$urandom, $urandom});
		send(MODE_GET, '1, '1, '0);
		// A duplicate key appears once the searched range grows again.
		write_lines(5'd1);
		send(MODE_PUT, key_node[5], key_block[5], {$urandom, $urandom});
		write_lines(5'd16);
		send(MODE_GET, key_node[5], key_block[5], '0);
		send(MODE_GET, key_node[16], key_block[16], '0);

		random_phase(85, 5'd16, 1'b1, 1'b0);
		random_phase(85, 5'd1, 1'b0, 1'b0);
		random_phase(85, 5'd0, 1'b0, 1'b0);
		random_phase(85, 5'd31, 1'b0, 1'b0);
		random_phase(85, 5'd17, 1'b0, 1'b0);
		random_phase(85, 5'd4, 1'b0, 1'b0);
		random_phase(85, 5'd2, 1'b0, 1'b0);
		random_phase(85, 5'd8, 1'b0, 1'b1);
		random_phase(85, 5'($urandom_range(31)), 1'b0, 1'b0);
		random_phase(85, 5'd16, 1'b0, 1'b0);

		settle();
		repeat (40) @(posedge clk);
		$display("Checked %0d result words (%0d hits) over %0d line-count settings,",
			words_checked, hits_seen, settings_used);
		$display("including empty, full, evicting and duplicate-line cases with stalls.");
		if (fails == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/abclru_pkg.sv
hdl/abclru_scan.sv
hdl/assoc_block_cache_lru.sv
bench/assoc_block_cache_lru_tb.sv
